// ----- rtl/smtbl_pkg.sv -----
// Shared types and codes for the semaphore table engine.
// No dependencies.
package smtbl_pkg;

	// Request codes
	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_UP      = 2'd1,
		REQ_DOWN    = 2'd2,
		REQ_DESTROY = 2'd3
	} req_t;

	// Status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_TABLE_FULL = 2'd1;
	localparam logic [1:0] ST_QUEUE_FULL = 2'd2;

	localparam int KEY_W = 32;
	localparam int CNT_W = 16;
	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

	// One result transaction
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] alloc_index;
		logic       caller_blocked;
		logic       wake_valid;
		logic [3:0] wake_task;
		logic       last;
	} result_t;

endpackage

// ----- rtl/smtbl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module smtbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port that holds when not read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/smtbl_outreg.sv -----
// Output register for result transactions.
// Depends on smtbl_pkg.
module smtbl_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld,
	input  smtbl_pkg::result_t res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [3:0]        alloc_index,
	output logic              caller_blocked,
	output logic              wake_valid,
	output logic [3:0]        wake_task,
	output logic              last
);
	import smtbl_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || !out_stall;

	// Load a new result or drop the one taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			res_q <= res;
		end
	end

	assign out_valid      = valid_q;
	assign status         = res_q.status;
	assign alloc_index    = res_q.alloc_index;
	assign caller_blocked = res_q.caller_blocked;
	assign wake_valid     = res_q.wake_valid;
	assign wake_task      = res_q.wake_task;
	assign last           = res_q.last;

`ifndef SYNTHESIS
	a_no_load_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> free) else $error("result loaded while output register busy");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |=> valid_q) else $error("stalled result dropped");
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.caller_blocked |-> !res_q.wake_valid)
		else $error("blocked and wake in one result");
`endif
endmodule

// ----- rtl/semaphore_table_engine_top.sv -----
// Semaphore table engine top level: sequencer, slot and waiter memories.
// Depends on smtbl_pkg, smtbl_ram, smtbl_outreg.
//
// Usage: one request transaction enters on in_valid/in_stall (req_type,
// sem_index, sem_key, init_value, task_id). Results leave on
// out_valid/out_stall; every request gives one result, except a destroy
// of a slot with waiters, which gives one per waiter (last marks the final
// one). A result is loaded into the output register from the decode state;
// for an up that wakes a waiter and for the first result of a destroy that
// drains waiters, it is loaded after the waiter memory read. A request
// occupies the sequencer from accept until its last result is loaded; the
// next request is taken in the cycle after the last result is loaded. The
// rate is set by the slot memory read-modify-write and the waiter memory
// read of one entry per cycle while the output register is free.
// At reset all slots are free and all queues empty; memory contents are
// not cleared, per-slot flags mask stale head and length values.
// When the receiver stalls, the result holds in the output register and
// the sequencer waits; in_stall stays high until the request is done.
module semaphore_table_engine_top #(
	parameter int SEM_SLOTS = 16,
	parameter int MAX_TASKS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic [3:0]                           sem_index,
	input  logic signed [smtbl_pkg::KEY_W-1:0]   sem_key,
	input  logic signed [smtbl_pkg::CNT_W-1:0]   init_value,
	input  logic [3:0]                           task_id,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [3:0]                           alloc_index,
	output logic                                 caller_blocked,
	output logic                                 wake_valid,
	output logic [3:0]                           wake_task,
	output logic                                 last
);
	import smtbl_pkg::*;

	localparam int SW   = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
	localparam int HW   = $clog2(MAX_TASKS);
	localparam int LW   = $clog2(MAX_TASKS + 1);
	localparam int WD   = SEM_SLOTS * MAX_TASKS;
	localparam int WAW  = $clog2(WD);
	localparam int SRW  = KEY_W + CNT_W + HW + LW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEC,
		S_WAKE,
		S_DRAIN
	} state_t;

	state_t st_q, st_d;

	// Request registers
	req_t                     req_q;
	logic [3:0]               idx_q;
	logic [KEY_W-1:0]         key_q;
	logic signed [CNT_W-1:0]  init_q;
	logic [3:0]               task_q;
	logic                     hlok_q;
	logic [HW-1:0]            head_q, head_d;
	logic [LW-1:0]            len_q, len_d;

	logic [SEM_SLOTS-1:0]     valid_q, wr_q;
	logic                     set_valid, clr_valid;

	// Memory ports
	logic                     s_we, s_re;
	logic [SW-1:0]            s_waddr, s_raddr;
	logic [SRW-1:0]           s_wdata, s_rdata;
	logic                     w_we, w_re;
	logic [WAW-1:0]           w_waddr, w_raddr;
	logic [3:0]               w_wdata, w_rdata;

	logic                     ofree, res_ld;
	result_t                  res;

	// Decoded slot contents
	logic signed [CNT_W-1:0]  cnt_rd, cnt_up, cnt_dn;
	logic [KEY_W-1:0]         key_rd;
	logic [HW-1:0]            head_rd, head_nx, tail;
	logic [LW-1:0]            len_rd;
	logic [HW:0]              tail_sum;
	logic [SW-1:0]            slot, free_idx;
	logic                     free_found, in_rng;

	function automatic logic [WAW-1:0] waddr_of(input logic [SW-1:0] sl,
		input logic [HW-1:0] ix);
		waddr_of = WAW'(int'(sl) * MAX_TASKS + int'(ix));
	endfunction

	smtbl_ram #(.WIDTH(SRW), .DEPTH(SEM_SLOTS)) u_slot_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	smtbl_ram #(.WIDTH(4), .DEPTH(WD)) u_wait_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.re(w_re), .raddr(w_raddr), .rdata(w_rdata)
	);

	smtbl_outreg u_out (
		.clk(clk), .arst_n(arst_n), .ld(res_ld), .res(res), .free(ofree),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.alloc_index(alloc_index), .caller_blocked(caller_blocked),
		.wake_valid(wake_valid), .wake_task(wake_task), .last(last)
	);

	assign in_stall = (st_q != S_IDLE);
	assign slot     = SW'(idx_q);
	assign in_rng   = int'(idx_q) < SEM_SLOTS;

	// Unpack slot entry; head and length read as zero until first written
	assign key_rd  = s_rdata[SRW-1 -: KEY_W];
	assign cnt_rd  = s_rdata[HW+LW +: CNT_W];
	assign head_rd = hlok_q ? s_rdata[LW +: HW] : '0;
	assign len_rd  = hlok_q ? s_rdata[LW-1:0] : '0;
	assign cnt_up  = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 16'sd1;
	assign cnt_dn  = (cnt_rd == CNT_MIN) ? cnt_rd : cnt_rd - 16'sd1;
	assign head_nx = (head_rd == HW'(MAX_TASKS - 1)) ? '0 : head_rd + 1'b1;
	assign tail_sum = (HW+1)'(head_rd) + (HW+1)'(len_rd);
	assign tail = (tail_sum >= (HW+1)'(MAX_TASKS)) ?
		HW'(tail_sum - (HW+1)'(MAX_TASKS)) : HW'(tail_sum);

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// Sequencer decisions and memory control
	always_comb begin
		st_d      = st_q;
		head_d    = head_q;
		len_d     = len_q;
		s_re      = 1'b0;
		s_raddr   = SW'(sem_index);
		s_we      = 1'b0;
		s_waddr   = slot;
		s_wdata   = s_rdata;
		w_we      = 1'b0;
		w_waddr   = waddr_of(slot, tail);
		w_wdata   = task_q;
		w_re      = 1'b0;
		w_raddr   = waddr_of(slot, head_rd);
		set_valid = 1'b0;
		clr_valid = 1'b0;
		res_ld    = 1'b0;
		res       = '0;
		res.last  = 1'b1;
		unique case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					s_re = 1'b1;
					st_d = S_DEC;
				end
			end
			S_DEC: begin
				if (ofree) begin
					st_d = S_IDLE;
					if (req_q == REQ_ALLOC) begin
						res_ld = 1'b1;
						if (free_found) begin
							set_valid       = 1'b1;
							s_we            = 1'b1;
							s_waddr         = free_idx;
							s_wdata         = {key_q, init_q, HW'(0), LW'(0)};
							res.alloc_index = 4'(free_idx);
						end else begin
							res.status = ST_TABLE_FULL;
						end
					end else if (!in_rng) begin
						res_ld = 1'b1;
					end else if (req_q == REQ_DESTROY) begin
						clr_valid = 1'b1;
						s_we      = 1'b1;
						s_wdata   = {key_rd, cnt_rd, HW'(0), LW'(0)};
						if (len_rd == '0) begin
							res_ld = 1'b1;
						end else begin
							w_re   = 1'b1;
							head_d = head_nx;
							len_d  = len_rd;
							st_d   = S_DRAIN;
						end
					end else if (!valid_q[slot]) begin
						res_ld = 1'b1;
					end else if (req_q == REQ_UP) begin
						s_we = 1'b1;
						if (cnt_up <= 16'sd0 && len_rd != '0) begin
							s_wdata = {key_rd, cnt_up, head_nx, LW'(len_rd - 1'b1)};
							w_re    = 1'b1;
							st_d    = S_WAKE;
						end else begin
							s_wdata = {key_rd, cnt_up, head_rd, len_rd};
							res_ld  = 1'b1;
						end
					end else begin
						res_ld = 1'b1;
						if (cnt_dn < 16'sd0) begin
							if (len_rd == LW'(MAX_TASKS)) begin
								res.status = ST_QUEUE_FULL;
							end else begin
								w_we               = 1'b1;
								s_we               = 1'b1;
								s_wdata            = {key_rd, cnt_dn, head_rd,
									LW'(len_rd + 1'b1)};
								res.caller_blocked = 1'b1;
							end
						end else begin
							s_we    = 1'b1;
							s_wdata = {key_rd, cnt_dn, head_rd, len_rd};
						end
					end
				end
			end
			S_WAKE: begin
				if (ofree) begin
					res_ld         = 1'b1;
					res.wake_valid = 1'b1;
					res.wake_task  = w_rdata;
					st_d           = S_IDLE;
				end
			end
			S_DRAIN: begin
				w_raddr = waddr_of(slot, head_q);
				if (ofree) begin
					res_ld         = 1'b1;
					res.wake_valid = 1'b1;
					res.wake_task  = w_rdata;
					res.last       = (len_q == LW'(1));
					if (len_q == LW'(1)) begin
						st_d = S_IDLE;
					end else begin
						w_re   = 1'b1;
						head_d = (head_q == HW'(MAX_TASKS - 1)) ? '0 : head_q + 1'b1;
						len_d  = len_q - 1'b1;
					end
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// Hold state and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			valid_q <= '0;
			wr_q    <= '0;
		end else begin
			st_q <= st_d;
			if (set_valid) begin
				valid_q[free_idx] <= 1'b1;
				wr_q[free_idx]    <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[slot] <= 1'b0;
				wr_q[slot]    <= 1'b1;
			end
		end
	end

	// Capture request and drain position
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			req_q  <= req_t'(req_type);
			idx_q  <= sem_index;
			key_q  <= sem_key;
			init_q <= init_value;
			task_q <= task_id;
			hlok_q <= (int'(sem_index) < SEM_SLOTS) && wr_q[SW'(sem_index)];
		end
		head_q <= head_d;
		len_q  <= len_d;
	end

`ifndef SYNTHESIS
	a_dec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> st_q == S_DEC) else $error("accept not decoded");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DRAIN |-> len_q != '0) else $error("drain with empty queue");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_ld |-> ofree) else $error("result loaded while busy");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_we |-> st_q == S_DEC) else $error("slot write outside decode");
`endif
endmodule
